FILE: sv/vcr_pkg.sv
// ---------------------------------------------------------------------------
// vcr_pkg: shared constants and arithmetic for the voltage change reporter
// Scaling of converter counts to millivolts and the volts/tenths digits.
// ---------------------------------------------------------------------------
package vcr_pkg;

    localparam int unsigned ADC_W     = 10;
    localparam int unsigned MV_W      = 15;
    localparam int unsigned LAST_MV_W = 16;
    localparam int unsigned THRESH_W  = 16;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned VOLTS_W   = 5;
    localparam int unsigned TENTHS_W  = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = 2'd1;

    localparam logic [THRESH_W-1:0]  THRESH_RESET  = 16'd200;
    localparam logic [CNT_W-1:0]     HOLDOFF_RESET = 32'd500;
    localparam logic [LAST_MV_W-1:0] NEVER_REPORTED = 16'hFFFF;

    // scaling: count * 3300 * 92 / (1023 * 10)
    localparam int unsigned SUPPLY_MV   = 3300;
    localparam int unsigned DIV_TOTAL_K = 92;
    localparam int unsigned DIV_LOW_K   = 10;
    localparam int unsigned FULL_SCALE  = 1023;
    localparam int unsigned MV_NUM      = SUPPLY_MV * DIV_TOTAL_K / DIV_LOW_K;  // 30360
    localparam int unsigned PROD_W      = 25;
    // 1/1023 is approximated by 1025 / 2^20, low by less than one
    localparam int unsigned RECIP_MUL   = FULL_SCALE + 2;
    localparam int unsigned RECIP_SH    = 20;
    localparam int unsigned RECIP_W     = PROD_W + 11;

    // digit extraction reciprocals (exact over the reading range)
    localparam int unsigned DIV1000_MUL = 16778;
    localparam int unsigned DIV1000_SH  = 24;
    localparam int unsigned DIV100_MUL  = 41;
    localparam int unsigned DIV100_SH   = 12;

    function automatic logic [MV_W-1:0] scale_to_mv(input logic [ADC_W-1:0] count);
        logic [PROD_W-1:0]   x;
        logic [RECIP_W-1:0]  p;
        logic [MV_W-1:0]     q;
        logic [PROD_W:0]     r;
        x = PROD_W'(count) * PROD_W'(MV_NUM);
        p = RECIP_W'(x) * RECIP_W'(RECIP_MUL);
        q = p[RECIP_SH +: MV_W];
        r = (PROD_W+1)'(x) - (PROD_W+1)'(q) * (PROD_W+1)'(FULL_SCALE);
        // estimate is at most one short
        if (r >= (PROD_W+1)'(FULL_SCALE)) begin
            q = q + MV_W'(1);
        end
        return q;
    endfunction

    function automatic logic [VOLTS_W-1:0] whole_of(input logic [MV_W-1:0] mv);
        logic [MV_W+DIV1000_SH-1:0] p;
        p = (MV_W+DIV1000_SH)'(mv) * (MV_W+DIV1000_SH)'(DIV1000_MUL);
        return p[DIV1000_SH +: VOLTS_W];
    endfunction

    function automatic logic [TENTHS_W-1:0] tenths_of(input logic [MV_W-1:0] mv,
                                                      input logic [VOLTS_W-1:0] whole);
        logic [9:0]  rem;
        logic [17:0] p;
        rem = 10'(mv - MV_W'(whole) * MV_W'(1000));
        p   = 18'(rem) * 18'(DIV100_MUL);
        return p[DIV100_SH +: TENTHS_W];
    endfunction

endpackage

FILE: sv/voltage_change_reporter_top.sv
// ---------------------------------------------------------------------------
// voltage_change_reporter_top: deadband report-on-change with holdoff
// Scales converter counts to millivolts and flags samples worth reporting.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one 10-bit converter
//   count per transaction. Output channel (o_out_valid / i_out_stall) gives
//   one result per input: reading in millivolts, report flag, whole volts
//   and tenths digit.
//   Three register stages: input register, scaled-millivolt register and
//   result register. Throughput is one transaction per cycle while the
//   receiver does not stall. The report decision and its state update
//   sit in the last stage, so back-to-back samples see the previous
//   sample's report.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
//   change threshold in mV, index 1 the holdoff in items. Other indexes are
//   ignored. Write only while the pipeline is empty.
//   Reset (synchronous, active low) empties the pipeline, restores the
//   registers to 200 mV / 500 items and marks the block as never reported.
//   When the receiver stalls, the result is held and stages fill up; the
//   input stalls only once every stage holds a transaction.
// ---------------------------------------------------------------------------
module voltage_change_reporter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [vcr_pkg::ADC_W-1:0]          i_adc_count,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [vcr_pkg::MV_W-1:0]           o_reading_mv,
    output logic                               o_report_now,
    output logic [vcr_pkg::VOLTS_W-1:0]        o_whole_volts,
    output logic [vcr_pkg::TENTHS_W-1:0]       o_tenth_volts,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vcr_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    logic                               r_s0_valid;
    logic [vcr_pkg::ADC_W-1:0]          r_s0_count;
    logic                               r_s1_valid;
    logic [vcr_pkg::MV_W-1:0]           r_s1_mv;
    logic                               r_out_valid;
    logic [vcr_pkg::MV_W-1:0]           r_out_mv;
    logic                               r_out_report;
    logic [vcr_pkg::VOLTS_W-1:0]        r_out_whole;
    logic [vcr_pkg::TENTHS_W-1:0]       r_out_tenths;

    logic [vcr_pkg::THRESH_W-1:0]       r_threshold;
    logic [vcr_pkg::CNT_W-1:0]          r_holdoff;
    logic [vcr_pkg::CNT_W-1:0]          r_item_cnt;
    logic [vcr_pkg::CNT_W-1:0]          r_last_item;
    logic [vcr_pkg::LAST_MV_W-1:0]      r_last_mv;

    logic                               out_rdy;
    logic                               s1_rdy;
    logic                               s0_rdy;
    logic                               in_take;
    logic                               s0_move;
    logic                               s1_move;

    logic [vcr_pkg::CNT_W-1:0]          n_item_cnt;
    logic [vcr_pkg::LAST_MV_W-1:0]      mv_ext;
    logic [vcr_pkg::LAST_MV_W-1:0]      delta;
    logic                               never;
    logic                               moved;
    logic                               spaced;
    logic                               report;
    logic [vcr_pkg::VOLTS_W-1:0]        whole;

    assign out_rdy = !r_out_valid || !i_out_stall;
    assign s1_rdy  = !r_s1_valid || out_rdy;
    assign s0_rdy  = !r_s0_valid || s1_rdy;
    assign in_take = i_in_valid && s0_rdy;
    assign s0_move = r_s0_valid && s1_rdy;
    assign s1_move = r_s1_valid && out_rdy;

    // report decision on the sample leaving the millivolt stage
    always_comb begin
        n_item_cnt = r_item_cnt + vcr_pkg::CNT_W'(1);
        mv_ext     = vcr_pkg::LAST_MV_W'(r_s1_mv);
        delta      = (mv_ext > r_last_mv) ? (mv_ext - r_last_mv) : (r_last_mv - mv_ext);
        never      = (r_last_mv == vcr_pkg::NEVER_REPORTED);
        moved      = (delta >= r_threshold);
        spaced     = ((n_item_cnt - r_last_item) >= r_holdoff);
        report     = (never || moved) && spaced;
        whole      = vcr_pkg::whole_of(r_s1_mv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_threshold <= vcr_pkg::THRESH_RESET;
            r_holdoff   <= vcr_pkg::HOLDOFF_RESET;
            r_item_cnt  <= '0;
            r_last_item <= '0;
            r_last_mv   <= vcr_pkg::NEVER_REPORTED;
        end else begin
            if (s0_rdy) begin
                r_s0_valid <= i_in_valid;
            end
            if (s1_rdy) begin
                r_s1_valid <= r_s0_valid;
            end
            if (out_rdy) begin
                r_out_valid <= r_s1_valid;
            end
            if (s1_move) begin
                r_item_cnt <= n_item_cnt;
                if (report) begin
                    r_last_item <= n_item_cnt;
                    r_last_mv   <= mv_ext;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vcr_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[vcr_pkg::THRESH_W-1:0];
                    vcr_pkg::REG_HOLDOFF:   r_holdoff   <= i_cfg_data[vcr_pkg::CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s0_count <= i_adc_count;
        end
        if (s0_move) begin
            r_s1_mv <= vcr_pkg::scale_to_mv(r_s0_count);
        end
        if (s1_move) begin
            r_out_mv     <= r_s1_mv;
            r_out_report <= report;
            r_out_whole  <= whole;
            r_out_tenths <= vcr_pkg::tenths_of(r_s1_mv, whole);
        end
    end

    assign o_in_stall    = !s0_rdy;
    assign o_out_valid   = r_out_valid;
    assign o_reading_mv  = r_out_mv;
    assign o_report_now  = r_out_report;
    assign o_whole_volts = r_out_whole;
    assign o_tenth_volts = r_out_tenths;
    assign o_cfg_ready   = 1'b1;

endmodule
